/* hw/rtl/nsl_pkg.sv */
`default_nettype none

package nsl_pkg;

    localparam int COORD_W = 11;
    localparam int LABEL_W = 2;
    localparam int DIST_W = 22;
    localparam int COUNT_W = 4;
    localparam int WORD_W = 32;
    localparam int MAX_LANDMARKS = 16;

    localparam int NUM_SITES_DEF = 10;
    localparam int NUM_LANDMARKS_DEF = 16;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Landmark coordinates, landmark 0 first.
    localparam logic [COORD_W-1:0] MARK_X [MAX_LANDMARKS] = '{
        11'd200, 11'd1400, 11'd1400, 11'd200,
        11'd800, 11'd800, 11'd200, 11'd1400,
        11'd500, 11'd1100, 11'd1100, 11'd500,
        11'd800, 11'd800, 11'd500, 11'd1100
    };

    localparam logic [COORD_W-1:0] MARK_Y [MAX_LANDMARKS] = '{
        11'd200, 11'd1000, 11'd200, 11'd1000,
        11'd200, 11'd1000, 11'd600, 11'd600,
        11'd400, 11'd800, 11'd400, 11'd800,
        11'd400, 11'd800, 11'd600, 11'd600
    };

endpackage

`default_nettype wire

/* hw/rtl/nsl_ifs.sv */
`default_nettype none

interface nsl_site_if;
    logic                        valid;
    logic                        ready;
    logic [nsl_pkg::COORD_W-1:0] site_x;
    logic [nsl_pkg::COORD_W-1:0] site_y;
    logic [nsl_pkg::LABEL_W-1:0] site_label;

    modport source (output valid, output site_x, output site_y, output site_label,
                    input ready);
    modport sink (input valid, input site_x, input site_y, input site_label,
                  output ready);
endinterface

interface nsl_result_if;
    logic                       valid;
    logic                       ready;
    logic [nsl_pkg::WORD_W-1:0] landmark_labels;

    modport source (output valid, output landmark_labels, input ready);
    modport sink (input valid, input landmark_labels, output ready);
endinterface

`default_nettype wire

/* hw/rtl/nsl_dist_unit.sv */
`default_nettype none

module nsl_dist_unit #(
    parameter logic [nsl_pkg::COORD_W-1:0] MARK_X = '0,
    parameter logic [nsl_pkg::COORD_W-1:0] MARK_Y = '0
) (
    input  wire logic [nsl_pkg::COORD_W-1:0] x,
    input  wire logic [nsl_pkg::COORD_W-1:0] y,
    output logic      [nsl_pkg::DIST_W-1:0]  sq_dist
);

    logic [nsl_pkg::COORD_W-1:0]  dx;
    logic [nsl_pkg::COORD_W-1:0]  dy;
    logic [2*nsl_pkg::COORD_W-1:0] dx_sq;
    logic [2*nsl_pkg::COORD_W-1:0] dy_sq;
    logic [2*nsl_pkg::COORD_W:0]   sum;

    assign dx = (x > MARK_X) ? x - MARK_X : MARK_X - x;
    assign dy = (y > MARK_Y) ? y - MARK_Y : MARK_Y - y;
    assign dx_sq = (2*nsl_pkg::COORD_W)'(dx) * (2*nsl_pkg::COORD_W)'(dx);
    assign dy_sq = (2*nsl_pkg::COORD_W)'(dy) * (2*nsl_pkg::COORD_W)'(dy);
    assign sum = {1'b0, dx_sq} + {1'b0, dy_sq};

    // Distances that do not fit clamp to all ones.
    assign sq_dist = (sum > {1'b0, nsl_pkg::DIST_MAX}) ? nsl_pkg::DIST_MAX
                                                       : sum[nsl_pkg::DIST_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/nearest_site_landmark_labeler.sv */
// A group's result word is registered after its last site passes the input and distance stages.
// Throughput: one site per cycle through a three-register pipeline (input, distance, best).
// The input stalls only when a finished group meets an output word not yet taken.
// Reset clears the pipeline valids, the site count and the output valid; a group's first
// site overwrites every landmark, so the distance and label stores need no reset.
`default_nettype none

module nearest_site_landmark_labeler #(
    parameter int NUM_SITES = nsl_pkg::NUM_SITES_DEF,
    parameter int NUM_LANDMARKS = nsl_pkg::NUM_LANDMARKS_DEF
) (
    input wire logic       clk,
    input wire logic       rst_n,
    nsl_site_if.sink       site,
    nsl_result_if.source   result
);

    localparam logic [nsl_pkg::COUNT_W-1:0] LAST_COUNT = nsl_pkg::COUNT_W'(NUM_SITES - 1);

    // Input stage.
    logic                        s1_valid_reg;
    logic [nsl_pkg::COORD_W-1:0] s1_x_reg;
    logic [nsl_pkg::COORD_W-1:0] s1_y_reg;
    logic [nsl_pkg::LABEL_W-1:0] s1_label_reg;

    // Distance stage.
    logic                        s2_valid_reg;
    logic [nsl_pkg::LABEL_W-1:0] s2_label_reg;
    logic [nsl_pkg::DIST_W-1:0]  s2_dist_reg [NUM_LANDMARKS];
    logic [nsl_pkg::DIST_W-1:0]  site_dist [NUM_LANDMARKS];

    // Best-so-far state.
    logic [nsl_pkg::DIST_W-1:0]  best_dist_reg [NUM_LANDMARKS];
    logic [nsl_pkg::DIST_W-1:0]  best_dist_next [NUM_LANDMARKS];
    logic [nsl_pkg::LABEL_W-1:0] best_label_reg [NUM_LANDMARKS];
    logic [nsl_pkg::LABEL_W-1:0] best_label_next [NUM_LANDMARKS];
    logic [nsl_pkg::COUNT_W-1:0] sites_seen_reg;

    logic                        result_valid_reg;
    logic [nsl_pkg::WORD_W-1:0]  result_word_reg;
    logic [nsl_pkg::WORD_W-1:0]  result_word_next;

    logic s1_en;
    logic s2_en;
    logic s2_last;
    logic s2_first;
    logic upd_stall;
    logic upd_fire;

    assign s2_last   = (sites_seen_reg == LAST_COUNT);
    assign s2_first  = (sites_seen_reg == '0);
    // Only a group's last site needs the output register free.
    assign upd_stall = s2_valid_reg && s2_last && result_valid_reg && !result.ready;
    assign upd_fire  = s2_valid_reg && !upd_stall;
    assign s2_en     = !s2_valid_reg || !upd_stall;
    assign s1_en     = !s1_valid_reg || s2_en;

    assign site.ready             = s1_en;
    assign result.valid           = result_valid_reg;
    assign result.landmark_labels = result_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_en)
        begin
            s1_valid_reg <= site.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && site.valid)
        begin
            s1_x_reg     <= site.site_x;
            s1_y_reg     <= site.site_y;
            s1_label_reg <= site.site_label;
        end
    end

    for (genvar g = 0; g < NUM_LANDMARKS; g++)
    begin : g_dist
        nsl_dist_unit #(
            .MARK_X (nsl_pkg::MARK_X[g]),
            .MARK_Y (nsl_pkg::MARK_Y[g])
        ) u_dist (
            .x       (s1_x_reg),
            .y       (s1_y_reg),
            .sq_dist (site_dist[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_en && s1_valid_reg)
        begin
            s2_label_reg <= s1_label_reg;
            s2_dist_reg  <= site_dist;
        end
    end

    // A strictly smaller distance wins, so ties keep the earlier site.
    always_comb
    begin
        for (int j = 0; j < NUM_LANDMARKS; j++)
        begin
            if (s2_first || (s2_dist_reg[j] < best_dist_reg[j]))
            begin
                best_dist_next[j]  = s2_dist_reg[j];
                best_label_next[j] = s2_label_reg;
            end
            else
            begin
                best_dist_next[j]  = best_dist_reg[j];
                best_label_next[j] = best_label_reg[j];
            end
        end
    end

    always_comb
    begin
        result_word_next = '0;
        for (int j = 0; j < NUM_LANDMARKS; j++)
        begin
            result_word_next[nsl_pkg::LABEL_W*j +: nsl_pkg::LABEL_W] = best_label_next[j];
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire)
        begin
            best_dist_reg  <= best_dist_next;
            best_label_reg <= best_label_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sites_seen_reg <= '0;
        end
        else if (upd_fire)
        begin
            sites_seen_reg <= s2_last ? '0 : sites_seen_reg + nsl_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (upd_fire && s2_last)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_fire && s2_last)
        begin
            result_word_reg <= result_word_next;
        end
    end

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sites_seen_reg <= LAST_COUNT)
        else $error("site count passed the group size");

    a_group_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        upd_fire && s2_last |=> result_valid_reg && sites_seen_reg == '0)
        else $error("finished group did not produce a result");

    a_stall_holds_site: assert property (@(posedge clk) disable iff (!rst_n)
        upd_stall |=> s2_valid_reg && $stable(s2_label_reg) && $stable(sites_seen_reg))
        else $error("stalled site was lost or the count moved");

    a_ready_only_on_block: assert property (@(posedge clk) disable iff (!rst_n)
        !site.ready |-> result_valid_reg && !result.ready)
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

/* test/nsl_label_checker.sv */
`default_nettype none

module nsl_label_checker #(
    parameter int NUM_SITES = nsl_pkg::NUM_SITES_DEF,
    parameter int NUM_LANDMARKS = nsl_pkg::NUM_LANDMARKS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    nsl_site_if          site,
    nsl_result_if        result,
    output int           mismatches,
    output int           words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import nsl_pkg::*;

    logic [DIST_W-1:0]  nearest_dist [MAX_LANDMARKS];
    logic [LABEL_W-1:0] nearest_label [MAX_LANDMARKS];
    int                 group_count;
    logic [WORD_W-1:0]  owed_words [$];

    function automatic logic [DIST_W-1:0] squared_gap(input logic [COORD_W-1:0] x,
                                                      input logic [COORD_W-1:0] y,
                                                      input int j);
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] dy;
        logic [DIST_W+1:0]  sum;
        dx = (x > MARK_X[j]) ? x - MARK_X[j] : MARK_X[j] - x;
        dy = (y > MARK_Y[j]) ? y - MARK_Y[j] : MARK_Y[j] - y;
        sum = (DIST_W+2)'(dx) * (DIST_W+2)'(dx) + (DIST_W+2)'(dy) * (DIST_W+2)'(dy);
        // Anything past the distance width pins at the all-ones value.
        return (sum > (DIST_W+2)'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
    endfunction

    task automatic clear_group();
        for (int j = 0; j < MAX_LANDMARKS; j++)
        begin
            nearest_dist[j] = DIST_MAX;
            nearest_label[j] = '0;
        end
        group_count = 0;
    endtask

    task automatic absorb_site(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                               input logic [LABEL_W-1:0] lab);
        logic [DIST_W-1:0] d;
        logic [WORD_W-1:0] word;
        bit                opens_group;
        opens_group = (group_count == 0);
        for (int j = 0; j < NUM_LANDMARKS && j < MAX_LANDMARKS; j++)
        begin
            d = squared_gap(x, y, j);
            // Only a strictly closer site wins, so ties keep the earlier label.
            if (opens_group || d < nearest_dist[j])
            begin
                nearest_dist[j] = d;
                nearest_label[j] = lab;
            end
        end
        group_count = (group_count + 1) % 16;
        if (group_count == NUM_SITES)
        begin
            word = '0;
            for (int j = 0; j < NUM_LANDMARKS && j < MAX_LANDMARKS; j++)
                word[2*j +: 2] = nearest_label[j];
            owed_words.push_back(word);
            clear_group();
        end
    endtask

    initial
    begin
        mismatches = 0;
        words_owed = 0;
        clear_group();
    end

    always @(posedge clk or negedge rst_n)
    begin
        logic [WORD_W-1:0] want;
        if (!rst_n)
        begin
            clear_group();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (owed_words.size() == 0)
                begin
                    $display("%0t: landmark labels expected none, got %h",
                             $time, result.landmark_labels);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (result.landmark_labels !== want)
                    begin
                        $display("%0t: landmark labels expected %h, got %h",
                                 $time, want, result.landmark_labels);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (site.valid && site.ready)
                absorb_site(site.site_x, site.site_y, site.site_label);
            words_owed = owed_words.size();
        end
    end

endmodule

`default_nettype wire

/* test/nearest_site_landmark_labeler_tb.sv */
`default_nettype none

module nearest_site_landmark_labeler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsl_pkg::*;

    logic clk;
    logic rst_n;
    bit   steady;
    int   mismatches;
    int   words_owed;

    nsl_site_if   site_ch ();
    nsl_result_if result_ch ();

    nearest_site_landmark_labeler dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .site   (site_ch),
        .result (result_ch)
    );

    nsl_label_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .site       (site_ch),
        .result     (result_ch),
        .mismatches (mismatches),
        .words_owed (words_owed)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Called on a falling edge; returns on the falling edge after the item is taken.
    task automatic send_site(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                             input logic [LABEL_W-1:0] lab);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            site_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        site_ch.valid <= 1'b1;
        site_ch.site_x <= x;
        site_ch.site_y <= y;
        site_ch.site_label <= lab;
        do @(posedge clk); while (!site_ch.ready);
        @(negedge clk);
    endtask

    task automatic drain_words();
        site_ch.valid <= 1'b0;
        do @(negedge clk); while (words_owed != 0);
    endtask

    // Result side: a fresh random stall, possibly none, before every item, none during steady stretches.
    initial
    begin
        int stall;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            @(negedge clk);
        end
    end

    initial
    begin
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] last_x;
        logic [COORD_W-1:0] last_y;
        int                 kind;
        int                 j;
        clk = 1'b0;
        rst_n = 1'b0;
        steady = 1'b0;
        site_ch.valid = 1'b0;
        site_ch.site_x = '0;
        site_ch.site_y = '0;
        site_ch.site_label = '0;
        last_x = '0;
        last_y = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Corners, exact landmark hits and a repeated site that must not steal a tie.
        send_site(11'd0, 11'd0, 2'd0);
        send_site(11'd2047, 11'd2047, 2'd1);
        send_site(11'd200, 11'd200, 2'd2);
        send_site(11'd200, 11'd200, 2'd3);
        send_site(11'd1400, 11'd1000, 2'd3);
        send_site(11'd1599, 11'd1199, 2'd1);
        send_site(11'd800, 11'd600, 2'd2);
        send_site(11'd2047, 11'd0, 2'd3);
        send_site(11'd0, 11'd2047, 2'd1);
        send_site(11'd1100, 11'd600, 2'd0);
        // A far first site saturates; a second saturated distance must not replace it.
        send_site(11'd2047, 11'd2047, 2'd3);
        send_site(11'd2047, 11'd2040, 2'd2);
        send_site(11'd0, 11'd2047, 2'd1);
        send_site(11'd2047, 11'd0, 2'd0);
        send_site(11'd1599, 11'd0, 2'd2);
        send_site(11'd0, 11'd1199, 2'd3);
        send_site(11'd1024, 11'd1024, 2'd1);
        send_site(11'd1023, 11'd1023, 2'd2);
        send_site(11'd500, 11'd600, 2'd0);
        send_site(11'd501, 11'd600, 2'd3);
        drain_words();

        for (int n = 0; n < 1600; n++)
        begin
            if (n % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (n == 800)
                drain_words();
            kind = $urandom_range(0, 15);
            if (kind < 2)
            begin
                x = COORD_W'($urandom_range(0, 2047));
                y = COORD_W'($urandom_range(0, 2047));
            end
            else if (kind < 5)
            begin
                // Close to a landmark, where near ties between sites are likely.
                j = $urandom_range(0, MAX_LANDMARKS - 1);
                x = MARK_X[j] + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
                y = MARK_Y[j] + COORD_W'($urandom_range(0, 8)) - COORD_W'(4);
            end
            else if (kind == 5)
            begin
                x = last_x;
                y = last_y;
            end
            else
            begin
                x = COORD_W'($urandom_range(0, 1599));
                y = COORD_W'($urandom_range(0, 1199));
            end
            send_site(x, y, LABEL_W'($urandom_range(0, 3)));
            last_x = x;
            last_y = y;
        end

        drain_words();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && words_owed == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
